// ===== rtl/core/apsc_pkg.sv =====
// Shared types, codes and constants of the PID speed regulator.
`timescale 1ns / 1ps

package apsc_pkg;

  // Field widths fixed by the item and register formats
  localparam int GAIN_W    = 16;
  localparam int TARGET_W  = 15;
  localparam int SDRIVE_W  = 16;
  localparam int RUNLEN_W  = 8;
  localparam int SPEED_W   = 16;
  localparam int ERR_W     = 18;
  localparam int OUT_ERR_W = 17;
  localparam int INTEG_W   = 32;
  localparam int COUNT_W   = 8;
  localparam int MODE_W    = 2;

  // Configuration bus
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TARGET_SPEED = 3'd3,
    REG_START_DRIVE  = 3'd4,
    REG_RUN_LENGTH   = 3'd5
  } reg_idx_t;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST       = 16'sd256;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST       = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST       = 16'sd0;
  localparam logic [TARGET_W-1:0]      TARGET_SPEED_RST = 15'd70;
  localparam logic [SDRIVE_W-1:0]      START_DRIVE_RST  = 16'd57343;
  localparam logic [RUNLEN_W-1:0]      RUN_LENGTH_RST   = 8'd100;

  // Last error after reset equals the default set point
  localparam logic signed [ERR_W-1:0]  PREV_ERR_RST     = 18'sd70;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [TARGET_W-1:0]      target_speed;
    logic [SDRIVE_W-1:0]      start_drive;
    logic [RUNLEN_W-1:0]      run_length;
  } cfg_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0] integ;
    logic signed [ERR_W-1:0]   prev_err;
    logic                      active;
    logic [COUNT_W-1:0]        count;
  } run_state_t;

endpackage

// ===== rtl/core/apsc_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module apsc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apsc_pkg::ADDR_W-1:0] paddr,
  input  logic [apsc_pkg::DATA_W-1:0] pwdata,
  output logic [apsc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output apsc_pkg::cfg_t              cfg
);
  import apsc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:       cfg_nxt.gain_p       = pwdata[GAIN_W-1:0];
        REG_GAIN_I:       cfg_nxt.gain_i       = pwdata[GAIN_W-1:0];
        REG_GAIN_D:       cfg_nxt.gain_d       = pwdata[GAIN_W-1:0];
        REG_TARGET_SPEED: cfg_nxt.target_speed = pwdata[TARGET_W-1:0];
        REG_START_DRIVE:  cfg_nxt.start_drive  = pwdata[SDRIVE_W-1:0];
        REG_RUN_LENGTH:   cfg_nxt.run_length   = pwdata[RUNLEN_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:       prdata = DATA_W'(cfg_r.gain_p[GAIN_W-1:0]);
      REG_GAIN_I:       prdata = DATA_W'(cfg_r.gain_i[GAIN_W-1:0]);
      REG_GAIN_D:       prdata = DATA_W'(cfg_r.gain_d[GAIN_W-1:0]);
      REG_TARGET_SPEED: prdata = DATA_W'(cfg_r.target_speed);
      REG_START_DRIVE:  prdata = DATA_W'(cfg_r.start_drive);
      REG_RUN_LENGTH:   prdata = DATA_W'(cfg_r.run_length);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= GAIN_P_RST;
      cfg_r.gain_i       <= GAIN_I_RST;
      cfg_r.gain_d       <= GAIN_D_RST;
      cfg_r.target_speed <= TARGET_SPEED_RST;
      cfg_r.start_drive  <= START_DRIVE_RST;
      cfg_r.run_length   <= RUN_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/apsc_pid_step.sv =====
// One regulator update: error, integral, PID step, drive clamp and run control.
`timescale 1ns / 1ps

module apsc_pid_step #(
  parameter int DRIVE_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic [apsc_pkg::MODE_W-1:0]         mode,
  input  logic signed [apsc_pkg::SPEED_W-1:0] speed,
  input  apsc_pkg::cfg_t                      cfg,
  input  apsc_pkg::run_state_t                st,
  input  logic [DRIVE_WIDTH-1:0]              drive,
  output apsc_pkg::run_state_t                st_nxt,
  output logic [DRIVE_WIDTH-1:0]              drive_nxt,
  output logic [apsc_pkg::COUNT_W-1:0]        shown_count,
  output logic                                finished
);
  import apsc_pkg::*;

  localparam int PROD_W = GAIN_W + ERR_W;
  localparam int IPROD_W = GAIN_W + INTEG_W;
  localparam int SUM_W  = IPROD_W + 2;
  localparam int ND_W   = SUM_W + 1;
  localparam int SD_W   = (DRIVE_WIDTH > SDRIVE_W) ? DRIVE_WIDTH : SDRIVE_W;
  localparam logic [DRIVE_WIDTH-1:0] DRIVE_MAX = '1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (GAIN_FRAC_BITS - 1);

  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [ERR_W-1:0]   diff;
  logic signed [PROD_W-1:0]  p_prod;
  logic signed [IPROD_W-1:0] i_prod;
  logic signed [PROD_W-1:0]  d_prod;
  logic signed [SUM_W-1:0]   pid_sum;
  logic signed [SUM_W-1:0]   pid_step;
  logic signed [ND_W-1:0]    nd;
  logic [DRIVE_WIDTH-1:0]    nd_clamp;
  logic [SD_W-1:0]           sd_ext;
  logic [DRIVE_WIDTH-1:0]    sd_clamp;
  logic [COUNT_W-1:0]        cnt_inc;
  logic                      len_hit;

  // Error, saturating integral and difference
  always_comb begin
    err       = $signed({{(ERR_W-TARGET_W){1'b0}}, cfg.target_speed}) - ERR_W'(speed);
    integ_sum = (INTEG_W+1)'(st.integ) + (INTEG_W+1)'(err);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
    diff = err - st.prev_err;
  end

  // Three gain products, summed and rounded to nearest (halves upward)
  always_comb begin
    p_prod   = PROD_W'(cfg.gain_p) * PROD_W'(err);
    i_prod   = IPROD_W'(cfg.gain_i) * IPROD_W'(integ_sat);
    d_prod   = PROD_W'(cfg.gain_d) * PROD_W'(diff);
    pid_sum  = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod);
    pid_step = (pid_sum + HALF) >>> GAIN_FRAC_BITS;
    nd       = ND_W'(drive) + ND_W'(pid_step);
    if (nd[ND_W-1]) begin
      nd_clamp = '0;
    end else if (nd > ND_W'(DRIVE_MAX)) begin
      nd_clamp = DRIVE_MAX;
    end else begin
      nd_clamp = nd[DRIVE_WIDTH-1:0];
    end
  end

  // Start drive limited to the drive range
  always_comb begin
    sd_ext = SD_W'(cfg.start_drive);
    if (sd_ext > SD_W'(DRIVE_MAX)) begin
      sd_clamp = DRIVE_MAX;
    end else begin
      sd_clamp = sd_ext[DRIVE_WIDTH-1:0];
    end
  end

  assign cnt_inc = st.count + COUNT_W'(1);
  assign len_hit = (cnt_inc >= cfg.run_length);

  always_comb begin
    st_nxt      = st;
    drive_nxt   = drive;
    shown_count = st.count;
    finished    = 1'b0;
    unique case (mode)
      MODE_START: begin
        if (!st.active) begin
          st_nxt.integ  = '0;
          st_nxt.active = 1'b1;
          st_nxt.count  = '0;
          drive_nxt     = sd_clamp;
          shown_count   = '0;
        end
      end
      MODE_STOP: begin
        if (st.active) begin
          st_nxt.active = 1'b0;
          st_nxt.count  = '0;
          finished      = 1'b1;
        end
      end
      MODE_SAMPLE: begin
        if (st.active) begin
          st_nxt.integ    = integ_sat;
          st_nxt.prev_err = err;
          drive_nxt       = nd_clamp;
          shown_count     = cnt_inc;
          if (len_hit) begin
            st_nxt.active = 1'b0;
            st_nxt.count  = '0;
            finished      = 1'b1;
          end else begin
            st_nxt.count  = cnt_inc;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

// ===== rtl/core/accumulating_pid_speed_control_core.sv =====
// Top level of the incremental PID motor speed regulator.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_mode, in_speed
// out_      output     out_valid / out_stall out_drive, out_error, out_running,
//                                            out_samples_taken, out_run_finished
// cfg       input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One beat per clock in and out while the result is not stalled; a beat passes
// the input register, then the result register, from which its result is
// presented. The whole PID update is one pass of logic with three parallel
// multiplies, so state feeds the next beat in the following cycle.
// Reset (rst_n low, synchronous) empties both stages, clears the run state, sets
// the last error to the default set point and loads the register defaults.
// A stalled result holds in the result register while the input register still
// takes one more beat; in_stall rises when both are full and the result is
// stalled.

module accumulating_pid_speed_control_core #(
  parameter int DRIVE_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [apsc_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [apsc_pkg::SPEED_W-1:0]  in_speed,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [DRIVE_WIDTH-1:0]               out_drive,
  output logic signed [apsc_pkg::OUT_ERR_W-1:0] out_error,
  output logic                                 out_running,
  output logic [apsc_pkg::COUNT_W-1:0]         out_samples_taken,
  output logic                                 out_run_finished,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [apsc_pkg::ADDR_W-1:0]          paddr,
  input  logic [apsc_pkg::DATA_W-1:0]          pwdata,
  output logic [apsc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import apsc_pkg::*;

  cfg_t cfg;

  // Input register
  logic                      in_vld_r;
  logic [MODE_W-1:0]         in_mode_r;
  logic signed [SPEED_W-1:0] in_speed_r;

  // Regulator state
  run_state_t             st_r;
  run_state_t             st_nxt;
  logic [DRIVE_WIDTH-1:0] drive_r;
  logic [DRIVE_WIDTH-1:0] drive_nxt;
  logic [COUNT_W-1:0]     shown_count;
  logic                   finished;

  // Result register
  logic                        out_vld_r;
  logic [DRIVE_WIDTH-1:0]      out_drive_r;
  logic signed [OUT_ERR_W-1:0] out_error_r;
  logic                        out_running_r;
  logic [COUNT_W-1:0]          out_count_r;
  logic                        out_fin_r;

  logic out_adv;
  logic move;

  apsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apsc_pid_step #(
    .DRIVE_WIDTH    (DRIVE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_step (
    .mode        (in_mode_r),
    .speed       (in_speed_r),
    .cfg         (cfg),
    .st          (st_r),
    .drive       (drive_r),
    .st_nxt      (st_nxt),
    .drive_nxt   (drive_nxt),
    .shown_count (shown_count),
    .finished    (finished)
  );

  // Result register frees when empty or drained this cycle
  assign out_adv  = !out_vld_r || !out_stall;
  // Beat in the input register moves on and commits its state update
  assign move     = in_vld_r && out_adv;
  assign in_stall = in_vld_r && !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_mode_r  <= in_mode;
      in_speed_r <= in_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.integ    <= '0;
      st_r.prev_err <= PREV_ERR_RST;
      st_r.active   <= 1'b0;
      st_r.count    <= '0;
      drive_r       <= '0;
    end else if (move) begin
      st_r    <= st_nxt;
      drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_drive_r   <= drive_nxt;
      out_error_r   <= st_nxt.prev_err[OUT_ERR_W-1:0];
      out_running_r <= st_nxt.active;
      out_count_r   <= shown_count;
      out_fin_r     <= finished;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_drive         = out_drive_r;
  assign out_error         = out_error_r;
  assign out_running       = out_running_r;
  assign out_samples_taken = out_count_r;
  assign out_run_finished  = out_fin_r;

  // A finished run never reports itself as still running
  a_fin_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_finished) |-> !out_running)
    else $error("run_finished beat shows running");

  // Sample count rests at zero whenever no run is active
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.active |-> (st_r.count == '0))
    else $error("sample count nonzero outside a run");

  // A beat leaving the input register always lands in the result register
  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_vld_r)
    else $error("beat lost between stages");

  // Drive only changes when a beat commits
  a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !move |=> $stable(drive_r))
    else $error("drive changed without a beat");

endmodule
